// File: rtl/mdf_pkg.sv
// Shared types, constants and CRC helpers for the message duplicate filter.
// No dependencies; the files that use it refer to it by scoped names.
`default_nettype none

package mdf_pkg;

    // Field widths
    localparam int AREA_W       = 4;
    localparam int CRC_W        = 16;
    localparam int BYTE_W       = 8;
    localparam int FILTER_IDX_W = 10;
    localparam int FILTER_BYTES = 1024;

    // CRC-16/CCITT settings
    localparam logic [CRC_W-1:0] CRC_INIT = 16'hFFFF;
    localparam logic [CRC_W-1:0] CRC_POLY = 16'h1021;

    // Special byte codes
    localparam logic [BYTE_W-1:0] BYTE_KLUDGE  = 8'h01;
    localparam logic [BYTE_W-1:0] BYTE_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] BYTE_LF      = 8'h0A;
    localparam logic [BYTE_W-1:0] BYTE_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] BYTE_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] BYTE_SOFT_CR = 8'h8D;
    localparam logic [BYTE_W-1:0] BYTE_NUL     = 8'h00;

    // Job queue between front and back
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;

    typedef enum logic [2:0] {
        CMD_START  = 3'd0,
        CMD_BODY   = 3'd1,
        CMD_HEADER = 3'd2,
        CMD_CHECK  = 3'd3,
        CMD_INSERT = 3'd4
    } t_cmd;

    // One filter job: a check (read a bit) or an insert (set a bit)
    typedef struct packed {
        logic              is_insert;
        logic [AREA_W-1:0] area;
        logic [CRC_W-1:0]  sig;
        logic [CRC_W-1:0]  crc_header;
    } t_job;

    // Table entry of the byte-wise CRC: the top byte pushed through 8 shifts
    function automatic logic [CRC_W-1:0] crc_tab(input logic [BYTE_W-1:0] idx);
        logic [CRC_W-1:0] c;
        c = {idx, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[CRC_W-1]) begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

    // Advance a CRC by one byte
    function automatic logic [CRC_W-1:0] crc_byte(input logic [CRC_W-1:0] crc,
                                                  input logic [BYTE_W-1:0] b);
        return {crc[7:0], 8'h00} ^ crc_tab(crc[15:8] ^ b);
    endfunction

    // Whitespace: tab to CR, and space
    function automatic logic is_blank(input logic [BYTE_W-1:0] b);
        return b inside {BYTE_SPACE, [BYTE_TAB:BYTE_CR]};
    endfunction

endpackage

`default_nettype wire

// File: rtl/message_duplicate_filter.sv
// Top level of the message duplicate filter: front end, job queue, back end.
// Depends on mdf_pkg, mdf_front, mdf_queue and mdf_back (which uses mdf_ram).
//
// Usage:
//   Input channel (i_valid / o_ready) carries one command word: start message,
//   body byte, header byte, check or insert. Bytes update the body and header
//   CRC-16/CCITT signatures inside the front end at once and give no result.
//   Check and insert words go through a four-entry queue to the back end,
//   which does a read-modify-write on the per-area bit filter (one byte per
//   cycle unless a check waits on the output; store has one read, one write port).
//   Output channel (o_valid / i_ready) carries one word per check: both CRCs
//   and the maybe-seen flag.
//   Throughput: one input word per cycle while o_ready is high.
//   Check path: queue, store read, result register.
//   Reset: CRCs go to 0xFFFF and the filter store is swept to zero, one byte a
//   cycle; o_ready stays low after reset is released until every stored byte
//   is cleared (16 areas or fewer are stored).
//   Receiver stall: the result register holds; checks wait in the back end and
//   queue, bytes and starts keep flowing until the queue fills.
`default_nettype none

module message_duplicate_filter #(
    parameter int AREA_COUNT = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [2:0]                   i_command,
    input  wire logic [mdf_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic [mdf_pkg::AREA_W-1:0]   i_area,
    input  wire logic [mdf_pkg::CRC_W-1:0]    i_sig_value,
    output logic                              o_valid,
    input  wire logic                         i_ready,
    output logic      [mdf_pkg::CRC_W-1:0]    o_crc_body,
    output logic      [mdf_pkg::CRC_W-1:0]    o_crc_header,
    output logic                              o_maybe_seen
);

    logic          accept;
    logic          push;
    mdf_pkg::t_job push_job;
    logic          q_full;
    logic          q_valid;
    mdf_pkg::t_job q_job;
    logic          q_pop;
    logic          clear_done;

    // Accept a word once the store is clear and the queue has room
    assign o_ready = clear_done && !q_full;
    assign accept  = i_valid && o_ready;

    mdf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_command   (i_command),
        .i_data_byte (i_data_byte),
        .i_area      (i_area),
        .i_sig_value (i_sig_value),
        .o_push      (push),
        .o_job       (push_job)
    );

    mdf_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (push_job),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    mdf_back #(
        .AREA_COUNT (AREA_COUNT)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_job_valid  (q_valid),
        .i_job        (q_job),
        .o_job_pop    (q_pop),
        .o_clear_done (clear_done),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_crc_body   (o_crc_body),
        .o_crc_header (o_crc_header),
        .o_maybe_seen (o_maybe_seen)
    );

endmodule

`default_nettype wire

// File: rtl/mdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`default_nettype none

module mdf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write, and read the old contents on a clash
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: rtl/mdf_front.sv
// Front end: takes input words, runs the body and header CRCs and hands
// check and insert jobs to the queue. Depends on mdf_pkg.
`default_nettype none

module mdf_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_accept,
    input  wire logic [2:0]                   i_command,
    input  wire logic [mdf_pkg::BYTE_W-1:0]   i_data_byte,
    input  wire logic [mdf_pkg::AREA_W-1:0]   i_area,
    input  wire logic [mdf_pkg::CRC_W-1:0]    i_sig_value,
    output logic                              o_push,
    output mdf_pkg::t_job                     o_job
);

    logic [mdf_pkg::CRC_W-1:0] r_body_crc, n_body_crc;
    logic [mdf_pkg::CRC_W-1:0] r_header_crc, n_header_crc;
    logic                      r_skipping, n_skipping;
    logic                      skip_after;

    // Skip state after this byte: a kludge marker opens, a line end closes
    always_comb begin
        skip_after = r_skipping;
        if (i_data_byte == mdf_pkg::BYTE_KLUDGE) begin
            skip_after = 1'b1;
        end else if (i_data_byte inside {mdf_pkg::BYTE_CR, mdf_pkg::BYTE_LF,
                                         mdf_pkg::BYTE_SOFT_CR}) begin
            skip_after = 1'b0;
        end
    end

    // Next CRC and skip state per command
    always_comb begin
        n_body_crc   = r_body_crc;
        n_header_crc = r_header_crc;
        n_skipping   = r_skipping;
        o_push       = 1'b0;
        if (i_accept) begin
            case (i_command)
                mdf_pkg::CMD_START: begin
                    n_body_crc   = mdf_pkg::CRC_INIT;
                    n_header_crc = mdf_pkg::CRC_INIT;
                    n_skipping   = 1'b0;
                end
                mdf_pkg::CMD_BODY: begin
                    n_skipping = skip_after;
                    if (!skip_after && !mdf_pkg::is_blank(i_data_byte)) begin
                        n_body_crc = mdf_pkg::crc_byte(r_body_crc, i_data_byte);
                    end
                end
                mdf_pkg::CMD_HEADER: begin
                    if (i_data_byte != mdf_pkg::BYTE_NUL) begin
                        n_header_crc = mdf_pkg::crc_byte(r_header_crc, i_data_byte);
                    end
                end
                mdf_pkg::CMD_CHECK,
                mdf_pkg::CMD_INSERT: begin
                    o_push = 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Build the job: a check carries the current body CRC
    always_comb begin
        o_job.is_insert  = (i_command == mdf_pkg::CMD_INSERT);
        o_job.area       = i_area;
        o_job.sig        = (i_command == mdf_pkg::CMD_INSERT) ? i_sig_value : r_body_crc;
        o_job.crc_header = r_header_crc;
    end

    // Hold the signature state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_body_crc   <= mdf_pkg::CRC_INIT;
            r_header_crc <= mdf_pkg::CRC_INIT;
            r_skipping   <= 1'b0;
        end else begin
            r_body_crc   <= n_body_crc;
            r_header_crc <= n_header_crc;
            r_skipping   <= n_skipping;
        end
    end

endmodule

`default_nettype wire

// File: rtl/mdf_queue.sv
// Short job queue between the front end and the filter back end.
// Depends on mdf_pkg for the job type and depth.
`default_nettype none

module mdf_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire mdf_pkg::t_job i_job,
    output logic               o_full,
    input  wire logic          i_pop,
    output logic               o_valid,
    output mdf_pkg::t_job      o_job
);

    mdf_pkg::t_job                 r_slot [mdf_pkg::QUEUE_DEPTH];
    logic [mdf_pkg::QPTR_W-1:0]    r_wr_ptr;
    logic [mdf_pkg::QPTR_W-1:0]    r_rd_ptr;
    logic [mdf_pkg::QPTR_W:0]      r_count;

    assign o_full  = (r_count == (mdf_pkg::QPTR_W+1)'(mdf_pkg::QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_job   = r_slot[r_rd_ptr];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_job;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

// File: rtl/mdf_back.sv
// Back end: clears the filter store after reset, then runs check and insert
// jobs as read-modify-write on the store and registers check results.
// Depends on mdf_pkg and mdf_ram.
`default_nettype none

module mdf_back #(
    parameter int AREA_COUNT = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_job_valid,
    input  wire mdf_pkg::t_job               i_job,
    output logic                             o_job_pop,
    output logic                             o_clear_done,
    output logic                             o_valid,
    input  wire logic                        i_ready,
    output logic      [mdf_pkg::CRC_W-1:0]   o_crc_body,
    output logic      [mdf_pkg::CRC_W-1:0]   o_crc_header,
    output logic                             o_maybe_seen
);

    localparam int AREA_LIMIT = 2 ** mdf_pkg::AREA_W;
    localparam int AREAS_USED = (AREA_COUNT < AREA_LIMIT) ? AREA_COUNT : AREA_LIMIT;
    localparam int DEPTH      = AREAS_USED * mdf_pkg::FILTER_BYTES;
    localparam int ADDR_W     = $clog2(DEPTH);
    localparam int FULL_W     = mdf_pkg::AREA_W + mdf_pkg::FILTER_IDX_W;

    // Clearing sweep
    logic              r_clear_done;
    logic [ADDR_W-1:0] r_clear_addr;

    // Lookup stage
    logic              r_s1_valid;
    mdf_pkg::t_job     r_s1_job;
    logic [ADDR_W-1:0] r_s1_addr;

    // Last write, for a read issued in the same cycle
    logic              r_fwd_valid;
    logic [ADDR_W-1:0] r_fwd_addr;
    logic [7:0]        r_fwd_data;

    // Result register
    logic                      r_out_valid;
    logic [mdf_pkg::CRC_W-1:0] r_out_body;
    logic [mdf_pkg::CRC_W-1:0] r_out_header;
    logic                      r_out_seen;

    logic [FULL_W-1:0] issue_full_addr;
    logic [ADDR_W-1:0] issue_addr;
    logic [7:0]        rdata;
    logic [7:0]        merged;
    logic [7:0]        set_data;
    logic [2:0]        s1_bit;
    logic              s1_in_range;
    logic              s1_seen;
    logic              out_free;
    logic              s1_adv;
    logic              ins_we;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    // Issue: address of the head job, byte from CRC bits 15..6
    assign issue_full_addr = {i_job.area, i_job.sig[15:6]};
    assign issue_addr      = issue_full_addr[ADDR_W-1:0];

    // Advance control
    assign out_free  = !r_out_valid || i_ready;
    assign s1_adv    = r_s1_valid && (r_s1_job.is_insert || out_free);
    assign o_job_pop = i_job_valid && r_clear_done && (!r_s1_valid || s1_adv);

    // Look up the bit, taking the newest write if it hit this byte
    assign s1_bit      = r_s1_job.sig[5:3];
    assign s1_in_range = int'(r_s1_job.area) < AREAS_USED;
    assign merged      = (r_fwd_valid && (r_fwd_addr == r_s1_addr)) ? r_fwd_data : rdata;
    assign s1_seen     = s1_in_range && merged[s1_bit];
    assign set_data    = merged | (8'h01 << s1_bit);
    assign ins_we      = s1_adv && r_s1_job.is_insert && s1_in_range;

    // Write port: zeros while clearing, then insert updates
    assign ram_we    = !r_clear_done || ins_we;
    assign ram_waddr = r_clear_done ? r_s1_addr : r_clear_addr;
    assign ram_wdata = r_clear_done ? set_data : 8'h00;

    mdf_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (o_job_pop),
        .i_raddr (issue_addr),
        .o_rdata (rdata)
    );

    // Sweep the store once after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clear_done <= 1'b0;
            r_clear_addr <= '0;
        end else if (!r_clear_done) begin
            r_clear_addr <= r_clear_addr + 1'b1;
            if (r_clear_addr == ADDR_W'(DEPTH - 1)) begin
                r_clear_done <= 1'b1;
            end
        end
    end

    // Lookup stage control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_fwd_valid <= 1'b0;
        end else begin
            if (o_job_pop) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_fwd_valid <= ins_we;
            end
        end
    end

    // Lookup stage payload and forwarding data
    always_ff @(posedge i_clk) begin
        if (o_job_pop) begin
            r_s1_job  <= i_job;
            r_s1_addr <= issue_addr;
        end
        if (s1_adv) begin
            r_fwd_addr <= r_s1_addr;
            r_fwd_data <= set_data;
        end
    end

    // Result register: load on a finished check, drop once taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && !r_s1_job.is_insert) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_adv && !r_s1_job.is_insert) begin
            r_out_body   <= r_s1_job.sig;
            r_out_header <= r_s1_job.crc_header;
            r_out_seen   <= s1_seen;
        end
    end

    assign o_clear_done = r_clear_done;
    assign o_valid      = r_out_valid;
    assign o_crc_body   = r_out_body;
    assign o_crc_header = r_out_header;
    assign o_maybe_seen = r_out_seen;

endmodule

`default_nettype wire

// File: tb/mdf_checker.sv
`timescale 1ns / 1ps
// Signature checker for the message duplicate filter: predicts each check report and compares it.
// Depends on mdf_pkg for the CRC settings, the byte codes and the command codes.

module mdf_checker #(
    parameter int AREA_N = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_ready_in,
    input  logic [2:0]                   i_command,
    input  logic [mdf_pkg::BYTE_W-1:0]   i_data_byte,
    input  logic [mdf_pkg::AREA_W-1:0]   i_area,
    input  logic [mdf_pkg::CRC_W-1:0]    i_sig_value,
    input  logic                         i_out_valid,
    input  logic                         i_ready,
    input  logic [mdf_pkg::CRC_W-1:0]    i_crc_body,
    input  logic [mdf_pkg::CRC_W-1:0]    i_crc_header,
    input  logic                         i_maybe_seen,
    output int                           o_fail_count,
    output int                           o_pending
);

    localparam int AREA_BYTES = mdf_pkg::FILTER_BYTES;

    typedef struct packed {
        logic [mdf_pkg::CRC_W-1:0] crc_body;
        logic [mdf_pkg::CRC_W-1:0] crc_header;
        logic                      maybe_seen;
    } t_check_report;

    // Shadow copy of the signatures, the kludge-line flag and the bit filters
    logic [mdf_pkg::CRC_W-1:0]  body_sig = mdf_pkg::CRC_INIT;
    logic [mdf_pkg::CRC_W-1:0]  header_sig = mdf_pkg::CRC_INIT;
    logic                       in_kludge = 1'b0;
    logic [7:0]                 seen_bits [AREA_N*AREA_BYTES];
    t_check_report              owed_reports[$];

    initial begin
        o_fail_count = 0;
        o_pending = 0;
        for (int k = 0; k < AREA_N*AREA_BYTES; k++) begin
            seen_bits[k] = 8'h00;
        end
    end

    // Push one byte through CRC-16/CCITT, MSB first
    function automatic logic [mdf_pkg::CRC_W-1:0] ccitt_step(
        input logic [mdf_pkg::CRC_W-1:0] crc,
        input logic [mdf_pkg::BYTE_W-1:0] b
    );
        logic [mdf_pkg::CRC_W-1:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ mdf_pkg::CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

    function automatic logic blank_byte(input logic [mdf_pkg::BYTE_W-1:0] b);
        return (b == mdf_pkg::BYTE_SPACE) || (b >= mdf_pkg::BYTE_TAB && b <= mdf_pkg::BYTE_CR);
    endfunction

    // Byte address of a signature's bit in the shadow filters: area base plus CRC bits 15..6
    function automatic int filter_addr(input logic [mdf_pkg::AREA_W-1:0] ar,
                                       input logic [mdf_pkg::CRC_W-1:0] sig);
        return int'(ar) * AREA_BYTES + int'(sig[15:6]);
    endfunction

    always @(posedge i_clk) begin : watch
        t_check_report got;
        t_check_report want;
        logic          hit;
        if (i_rst_n) begin
            // Compare a report word against the oldest prediction
            if (i_out_valid && i_ready) begin
                got = '{i_crc_body, i_crc_header, i_maybe_seen};
                if (owed_reports.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10) begin
                        $display("unexpected report: body %h header %h seen %b",
                                 got.crc_body, got.crc_header, got.maybe_seen);
                    end
                end else begin
                    want = owed_reports.pop_front();
                    if (got !== want) begin
                        o_fail_count++;
                        if (o_fail_count <= 10) begin
                            $display("report mismatch: expected body %h header %h seen %b, got body %h header %h seen %b",
                                     want.crc_body, want.crc_header, want.maybe_seen,
                                     got.crc_body, got.crc_header, got.maybe_seen);
                        end
                    end
                end
            end
            // Advance the shadow state on each accepted command word
            if (i_valid && i_ready_in) begin
                case (i_command)
                    mdf_pkg::CMD_START: begin
                        body_sig = mdf_pkg::CRC_INIT;
                        header_sig = mdf_pkg::CRC_INIT;
                        in_kludge = 1'b0;
                    end
                    mdf_pkg::CMD_BODY: begin
                        if (i_data_byte == mdf_pkg::BYTE_KLUDGE) begin
                            in_kludge = 1'b1;
                        end else if (i_data_byte == mdf_pkg::BYTE_CR ||
                                     i_data_byte == mdf_pkg::BYTE_LF ||
                                     i_data_byte == mdf_pkg::BYTE_SOFT_CR) begin
                            in_kludge = 1'b0;
                        end
                        if (!in_kludge && !blank_byte(i_data_byte)) begin
                            body_sig = ccitt_step(body_sig, i_data_byte);
                        end
                    end
                    mdf_pkg::CMD_HEADER: begin
                        // a NUL only ends a header string
                        if (i_data_byte != mdf_pkg::BYTE_NUL) begin
                            header_sig = ccitt_step(header_sig, i_data_byte);
                        end
                    end
                    mdf_pkg::CMD_CHECK: begin
                        hit = 1'b0;
                        if (int'(i_area) < AREA_N) begin
                            hit = seen_bits[filter_addr(i_area, body_sig)][body_sig[5:3]];
                        end
                        owed_reports.push_back('{body_sig, header_sig, hit});
                    end
                    mdf_pkg::CMD_INSERT: begin
                        if (int'(i_area) < AREA_N) begin
                            seen_bits[filter_addr(i_area, i_sig_value)][i_sig_value[5:3]] = 1'b1;
                        end
                    end
                    default: begin
                        // spare codes: drop
                    end
                endcase
            end
        end
        o_pending = owed_reports.size();
    end

endmodule

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Top of the message duplicate filter bench: clock, reset, command stimulus and verdict.
// Depends on mdf_pkg, message_duplicate_filter and mdf_checker.

module testbench;

    localparam int AREA_N       = 16;
    localparam int STALL_LIMIT  = 100000;
    localparam int RANDOM_WORDS = 650;
    localparam int LIB_SLOTS    = 8;
    localparam int LIB_WORDS    = 48;
    localparam int POOL_MAX     = 32;

    localparam logic [2:0] CMD_SPARE_LO = 3'd5;
    localparam logic [2:0] CMD_SPARE_HI = 3'd7;
    localparam logic [7:0] PRINT_LO     = 8'h21;
    localparam logic [7:0] PRINT_HI     = 8'h7E;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_ready;
    logic [2:0]  in_command = '0;
    logic [7:0]  in_data = '0;
    logic [3:0]  in_area = '0;
    logic [15:0] in_sig = '0;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [15:0] out_crc_body;
    logic [15:0] out_crc_header;
    logic        out_seen;

    int          report_errors;
    int          owed_reports;
    logic        in_took = 1'b0;
    logic        quiet = 1'b0;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          stall_left = 0;
    int          run_left = 0;
    logic [15:0] sig_pool[$];

    // Library of messages kept for replay
    logic [2:0]  lib_cmd  [LIB_SLOTS][LIB_WORDS];
    logic [7:0]  lib_data [LIB_SLOTS][LIB_WORDS];
    int          lib_len  [LIB_SLOTS];
    int          lib_count = 0;
    int          lib_next = 0;

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    message_duplicate_filter #(.AREA_COUNT(AREA_N)) dut (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .o_ready      (in_ready),
        .i_command    (in_command),
        .i_data_byte  (in_data),
        .i_area       (in_area),
        .i_sig_value  (in_sig),
        .o_valid      (out_valid),
        .i_ready      (out_ready),
        .o_crc_body   (out_crc_body),
        .o_crc_header (out_crc_header),
        .o_maybe_seen (out_seen)
    );

    mdf_checker #(.AREA_N(AREA_N)) sig_check (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_valid      (in_valid),
        .i_ready_in   (in_ready),
        .i_command    (in_command),
        .i_data_byte  (in_data),
        .i_area       (in_area),
        .i_sig_value  (in_sig),
        .i_out_valid  (out_valid),
        .i_ready      (out_ready),
        .i_crc_body   (out_crc_body),
        .i_crc_header (out_crc_header),
        .i_maybe_seen (out_seen),
        .o_fail_count (report_errors),
        .o_pending    (owed_reports)
    );

    // Note each accepted command word for the sender
    always @(posedge clk) begin
        in_took <= in_valid && in_ready;
    end

    // Keep recent body signatures so that inserts can hit real messages
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready) begin
            sig_pool.push_back(out_crc_body);
            if (sig_pool.size() > POOL_MAX) begin
                void'(sig_pool.pop_front());
            end
        end
    end

    // Idle length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Stall the report channel in random stretches
    always @(negedge clk) begin
        if (quiet) begin
            out_ready <= 1'b1;
        end else if (stall_left > 0) begin
            out_ready <= 1'b0;
            stall_left = stall_left - 1;
        end else if (run_left > 0) begin
            out_ready <= 1'b1;
            run_left = run_left - 1;
        end else begin
            out_ready <= 1'b1;
            run_left = $urandom_range(0, 12);
            stall_left = gap_len();
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("message_duplicate_filter regression: fail");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offer one command word and hold it until taken
    task automatic send_word(input logic [2:0] cmd, input logic [7:0] b,
                             input logic [3:0] ar, input logic [15:0] sg);
        int gap;
        gap = quiet ? 0 : gap_len();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid   <= 1'b1;
        in_command <= cmd;
        in_data    <= b;
        in_area    <= ar;
        in_sig     <= sg;
        @(negedge clk);
        while (!in_took) @(negedge clk);
        if (cmd < CMD_SPARE_LO) items_sent++;
    endtask

    // Hold off the sender until every report has come back
    task automatic drain();
        in_valid <= 1'b0;
        @(negedge clk);
        while (owed_reports != 0) @(negedge clk);
    endtask

    function automatic logic [3:0] pick_area();
        if ($urandom_range(0, 9) < 7) return 4'($urandom_range(0, 3));
        return 4'($urandom_range(0, 15));
    endfunction

    function automatic logic [7:0] pick_body_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45) return 8'($urandom_range(PRINT_HI, PRINT_LO));
        if (r < 55) return mdf_pkg::BYTE_SPACE;
        if (r < 60) return 8'($urandom_range(mdf_pkg::BYTE_CR, mdf_pkg::BYTE_TAB));
        if (r < 68) return ($urandom_range(0, 1) != 0) ? mdf_pkg::BYTE_CR : mdf_pkg::BYTE_LF;
        if (r < 74) return mdf_pkg::BYTE_KLUDGE;
        if (r < 78) return mdf_pkg::BYTE_SOFT_CR;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_header_byte();
        if ($urandom_range(0, 99) < 85) return 8'($urandom_range(PRINT_HI, PRINT_LO));
        return 8'($urandom_range(1, 255));
    endfunction

    // Build a message: start, three header strings, body; a few are broken
    task automatic build_message(input int slot);
        int n;
        int len;
        n = 0;
        if ($urandom_range(0, 9) != 0) begin
            lib_cmd[slot][n] = mdf_pkg::CMD_START;
            lib_data[slot][n] = 8'($urandom_range(0, 255));
            n++;
        end
        for (int s = 0; s < 3; s++) begin
            len = $urandom_range(0, 6);
            for (int k = 0; k < len; k++) begin
                lib_cmd[slot][n] = mdf_pkg::CMD_HEADER;
                lib_data[slot][n] = pick_header_byte();
                n++;
            end
            lib_cmd[slot][n] = mdf_pkg::CMD_HEADER;
            lib_data[slot][n] = mdf_pkg::BYTE_NUL;
            n++;
        end
        len = $urandom_range(3, 20);
        for (int k = 0; k < len; k++) begin
            lib_cmd[slot][n] = mdf_pkg::CMD_BODY;
            lib_data[slot][n] = pick_body_byte();
            n++;
        end
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, n);
        lib_len[slot] = n;
    endtask

    // Send a stored message, check it and sometimes mark a signature as seen
    task automatic play_message(input int slot);
        logic [15:0] sg;
        for (int k = 0; k < lib_len[slot]; k++) begin
            send_word(lib_cmd[slot][k], lib_data[slot][k], 4'($urandom), 16'($urandom));
        end
        send_word(mdf_pkg::CMD_CHECK, 8'($urandom), pick_area(), 16'($urandom));
        if ($urandom_range(0, 9) < 4) begin
            if (sig_pool.size() > 0 && $urandom_range(0, 4) != 0) begin
                sg = sig_pool[$urandom_range(0, sig_pool.size() - 1)];
            end else begin
                sg = 16'($urandom);
            end
            send_word(mdf_pkg::CMD_INSERT, 8'($urandom), pick_area(), sg);
        end
    endtask

    // Noise: any command code with any fields
    task automatic noise_burst();
        int n;
        n = $urandom_range(1, 6);
        for (int k = 0; k < n; k++) begin
            send_word(3'($urandom_range(0, 7)), 8'($urandom), 4'($urandom), 16'($urandom));
        end
    endtask

    initial begin : stimulus
        logic [7:0] opening_body [14];
        int         base;
        int         rounds;
        int         slot;
        opening_body = '{8'h41, mdf_pkg::BYTE_SPACE, mdf_pkg::BYTE_TAB, mdf_pkg::BYTE_CR,
                         mdf_pkg::BYTE_KLUDGE, 8'h55, mdf_pkg::BYTE_SOFT_CR, 8'h42,
                         mdf_pkg::BYTE_LF, mdf_pkg::BYTE_KLUDGE, 8'h99, mdf_pkg::BYTE_LF,
                         mdf_pkg::BYTE_NUL, 8'hFF};

        repeat (4) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: check straight after reset, then one message with every skip rule
        send_word(mdf_pkg::CMD_CHECK, 8'h00, 4'd0, 16'h0000);
        send_word(mdf_pkg::CMD_START, 8'hFF, 4'd15, 16'hFFFF);
        send_word(mdf_pkg::CMD_HEADER, mdf_pkg::BYTE_NUL, 4'd0, 16'h0000);
        send_word(mdf_pkg::CMD_HEADER, 8'hFF, 4'd15, 16'hFFFF);
        send_word(mdf_pkg::CMD_HEADER, 8'h41, 4'd5, 16'h5A5A);
        for (int k = 0; k < 14; k++) begin
            send_word(mdf_pkg::CMD_BODY, opening_body[k], 4'(k), 16'hA5A5);
        end
        send_word(mdf_pkg::CMD_CHECK, 8'h00, 4'd0, 16'h0000);
        send_word(CMD_SPARE_HI, 8'hFF, 4'd15, 16'hFFFF);

        // Wait for the report so its signature can be inserted
        drain();
        send_word(mdf_pkg::CMD_INSERT, 8'h00, 4'd15, sig_pool[$]);
        send_word(mdf_pkg::CMD_CHECK, 8'h00, 4'd15, 16'h0000);
        send_word(mdf_pkg::CMD_INSERT, 8'h00, 4'd0, mdf_pkg::CRC_INIT);
        send_word(mdf_pkg::CMD_START, 8'h00, 4'd0, 16'h0000);
        send_word(mdf_pkg::CMD_CHECK, 8'h00, 4'd0, 16'h0000);
        send_word(mdf_pkg::CMD_CHECK, 8'hFF, 4'd15, 16'h0000);
        send_word(CMD_SPARE_LO, 8'h00, 4'd0, 16'h0000);

        // Random: mostly whole messages, some replayed, the rest noise
        base = items_sent;
        rounds = 0;
        while (items_sent - base < RANDOM_WORDS) begin
            quiet <= ($urandom_range(0, 7) == 0);
            if (rounds % 40 == 39) drain();
            if ($urandom_range(0, 99) < 80) begin
                if (lib_count > 0 && $urandom_range(0, 2) == 0) begin
                    slot = $urandom_range(0, lib_count - 1);
                end else begin
                    slot = lib_next;
                    build_message(slot);
                    lib_next = (lib_next + 1) % LIB_SLOTS;
                    if (lib_count < LIB_SLOTS) lib_count++;
                end
                play_message(slot);
            end else begin
                noise_burst();
            end
            rounds++;
        end

        // Let the last reports come home
        in_valid <= 1'b0;
        @(negedge clk);
        while (owed_reports != 0) @(negedge clk);
        repeat (8) @(negedge clk);
        if (report_errors == 0 && owed_reports == 0) begin
            $display("message_duplicate_filter regression: pass");
        end else begin
            $display("message_duplicate_filter regression: fail");
        end
        $finish;
    end

endmodule
